// File: src/ils_pkg.sv
// Shared types and character constants for the integer literal scanner.
package ils_pkg;

    // ASCII codes used by the scanner
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_1         = 8'h31;
    localparam logic [7:0] CH_2         = 8'h32;
    localparam logic [7:0] CH_3         = 8'h33;
    localparam logic [7:0] CH_4         = 8'h34;
    localparam logic [7:0] CH_6         = 8'h36;
    localparam logic [7:0] CH_8         = 8'h38;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7a;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_UPPER_B   = 8'h42;
    localparam logic [7:0] CH_UPPER_C   = 8'h43;
    localparam logic [7:0] CH_UPPER_D   = 8'h44;
    localparam logic [7:0] CH_UPPER_H   = 8'h48;
    localparam logic [7:0] CH_UPPER_O   = 8'h4f;
    localparam logic [7:0] CH_UPPER_T   = 8'h54;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_LOWER_D   = 8'h64;
    localparam logic [7:0] CH_LOWER_H   = 8'h68;
    localparam logic [7:0] CH_LOWER_I   = 8'h69;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_O   = 8'h6f;
    localparam logic [7:0] CH_LOWER_S   = 8'h73;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    // Bases the scanner can be in
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_TER  = 5'd3;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;
    localparam logic [4:0] RADIX_NONE = 5'd0;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    typedef enum logic [1:0] {
        SIZE_INT8  = 2'd0,
        SIZE_INT16 = 2'd1,
        SIZE_INT32 = 2'd2,
        SIZE_INT64 = 2'd3
    } size_code_t;

    // Per-literal control state, everything except the accumulator
    typedef struct packed {
        logic [1:0]  position;
        logic        first_was_zero;
        logic [4:0]  current_base;
        logic        digits_stopped;
        logic        saw_u;
        logic [39:0] tail_window;
    } ils_ctl_t;

    localparam ils_ctl_t CTL_RESET = '{
        position:       POS_FIRST,
        first_was_zero: 1'b0,
        current_base:   RADIX_DEC,
        digits_stopped: 1'b0,
        saw_u:          1'b0,
        tail_window:    40'd0
    };

endpackage

// File: src/integer_literal_scanner_core.sv
// Top level of the integer literal scanner: input register, scan step, result register.
//
// Integer literal scanner. Feed the characters of one literal as beats on the
// s_ channel, one ASCII byte per beat, with s_tlast on the final character. A
// leading 0 followed by b, t, o/c, d or h/x (either case) selects base 2, 3,
// 8, 10 or 16; otherwise the base is 10. Backticks are skipped, and digit
// accumulation stops for good at the first lowercase s, u, i, n or t. Any
// non-alphanumeric character counts as digit 0, letters count 10..35, and the
// value wraps modulo 2^VALUE_WIDTH. After the last character one result beat
// appears on m_ carrying the value (sign-extended to 64 bits), the base, a
// signed flag (clear if a u appeared anywhere) and the size code from a
// trailing int8/int16/int32/int64 (int32 when none), and the scanner is back
// in its reset state for the next literal. Throughput is one character per
// cycle while no result waits on a stalled m_; the scan step updates the
// accumulator with one shift-and-add multiply. The last character is loaded
// into the input register and, once the step takes it, its result goes into
// the result register, which drives m_tvalid. Characters that are not last
// produce no beat. While a result waits on m_ with m_tready low, the scanner
// holds every character, last or not, and s_tready drops as soon as the input
// register is full.
module integer_literal_scanner_core
    import ils_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] literal_value, [68:64] radix,
                                   // [69] signed_flag, [71:70] size_code
);

    // Input register
    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;

    // Literal state
    ils_ctl_t               ctl_reg;
    ils_ctl_t               ctl_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;

    // Result register
    logic                   out_valid_reg;
    logic [71:0]            out_data_reg;

    logic                   proc_en;
    logic                   in_load;
    logic signed [VALUE_WIDTH-1:0] acc_signed;
    logic signed [63:0]     value_ext;
    size_code_t             size_code;

    // Process the held character unless it would need a busy result register.
    // A non-last character never touches m_, but gating on it too keeps the
    // control simple and costs nothing while the sink keeps up.
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;
    assign in_load  = s_tvalid && s_tready;

    ils_step #(
        .WIDTH (VALUE_WIDTH)
    ) u_step (
        .char_code (in_char_reg),
        .ctl       (ctl_reg),
        .acc       (acc_reg),
        .ctl_next  (ctl_next),
        .acc_next  (acc_next)
    );

    ils_suffix_decode u_suffix (
        .tail_window (ctl_next.tail_window),
        .size_code   (size_code)
    );

    // Sign-extend the wrapped value to the 64-bit result field
    assign acc_signed = acc_next;
    assign value_ext  = 64'(acc_signed);

    // Input register: hold a beat until the step takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (proc_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Literal state: advance per character, drop back to reset after the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= CTL_RESET;
            acc_reg <= '0;
        end else if (proc_en) begin
            if (in_last_reg) begin
                ctl_reg <= CTL_RESET;
                acc_reg <= '0;
            end else begin
                ctl_reg <= ctl_next;
                acc_reg <= acc_next;
            end
        end
    end

    // Result register: capture on the last character, release on m_tready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_en && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en && in_last_reg) begin
            out_data_reg <= {size_code, !ctl_next.saw_u, ctl_next.current_base, value_ext};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: src/ils_digit_acc.sv
// Multiply-accumulate of one digit: acc * base + digit, base from a fixed small set.
module ils_digit_acc
    import ils_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] acc,
    input  logic [4:0]       base,
    input  logic [5:0]       digit,
    output logic [WIDTH-1:0] sum
);

    logic [WIDTH-1:0] scaled;

    // Scale by shifts and adds only
    always_comb begin
        case (base)
            RADIX_BIN: scaled = acc << 1;
            RADIX_TER: scaled = (acc << 1) + acc;
            RADIX_OCT: scaled = acc << 3;
            RADIX_HEX: scaled = acc << 4;
            default:   scaled = (acc << 3) + (acc << 1);
        endcase
    end

    assign sum = scaled + WIDTH'(digit);

endmodule

// File: src/ils_suffix_decode.sv
// Maps the last five characters of a literal to its int size code.
module ils_suffix_decode
    import ils_pkg::*;
(
    input  logic [39:0] tail_window,
    output size_code_t  size_code
);

    logic [23:0] stem4;
    logic [23:0] stem5;

    assign stem4 = tail_window[31:8];
    assign stem5 = tail_window[39:16];

    // int8 wins over the five-character forms; int32 when nothing matches
    always_comb begin
        if (stem4 == {CH_LOWER_I, CH_LOWER_N, CH_LOWER_T} && tail_window[7:0] == CH_8) begin
            size_code = SIZE_INT8;
        end else if (stem5 == {CH_LOWER_I, CH_LOWER_N, CH_LOWER_T}
                     && tail_window[15:0] == {CH_1, CH_6}) begin
            size_code = SIZE_INT16;
        end else if (stem5 == {CH_LOWER_I, CH_LOWER_N, CH_LOWER_T}
                     && tail_window[15:0] == {CH_6, CH_4}) begin
            size_code = SIZE_INT64;
        end else begin
            size_code = SIZE_INT32;
        end
    end

endmodule

// File: src/ils_step.sv
// Next-state logic for one character: prefix detection, stop letters, digit accumulation.
module ils_step
    import ils_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic [7:0]       char_code,
    input  ils_ctl_t         ctl,
    input  logic [WIDTH-1:0] acc,
    output ils_ctl_t         ctl_next,
    output logic [WIDTH-1:0] acc_next
);

    function automatic logic [4:0] prefix_base(input logic [7:0] c);
        case (c)
            CH_LOWER_B, CH_UPPER_B:                         prefix_base = RADIX_BIN;
            CH_LOWER_T, CH_UPPER_T:                         prefix_base = RADIX_TER;
            CH_LOWER_O, CH_UPPER_O, CH_LOWER_C, CH_UPPER_C: prefix_base = RADIX_OCT;
            CH_LOWER_D, CH_UPPER_D:                         prefix_base = RADIX_DEC;
            CH_LOWER_H, CH_UPPER_H, CH_LOWER_X, CH_UPPER_X: prefix_base = RADIX_HEX;
            default:                                        prefix_base = RADIX_NONE;
        endcase
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        if (c inside {[CH_0:CH_9]}) begin
            char_value = 6'(c - CH_0);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            char_value = 6'(c - CH_LOWER_A + 8'd10);
        end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            char_value = 6'(c - CH_UPPER_A + 8'd10);
        end else begin
            char_value = 6'd0;
        end
    endfunction

    logic [4:0]       pbase;
    logic             prefix_taken;
    logic             is_stop;
    logic [WIDTH-1:0] acc_sum;

    assign pbase        = prefix_base(char_code);
    assign prefix_taken = (ctl.position == POS_SECOND) && ctl.first_was_zero
                          && (pbase != RADIX_NONE);
    assign is_stop      = char_code inside {CH_LOWER_S, CH_LOWER_U, CH_LOWER_I,
                                            CH_LOWER_N, CH_LOWER_T};

    ils_digit_acc #(
        .WIDTH (WIDTH)
    ) u_digit_acc (
        .acc   (acc),
        .base  (ctl.current_base),
        .digit (char_value(char_code)),
        .sum   (acc_sum)
    );

    always_comb begin
        ctl_next             = ctl;
        acc_next             = acc;
        ctl_next.tail_window = {ctl.tail_window[31:0], char_code};
        ctl_next.saw_u       = ctl.saw_u | (char_code == CH_LOWER_U);
        if (ctl.position == POS_FIRST) begin
            ctl_next.first_was_zero = (char_code == CH_0);
        end
        if (prefix_taken) begin
            ctl_next.current_base = pbase;
        end
        // Skip the prefix letter and separators; freeze after a stop letter
        if (!prefix_taken && !ctl.digits_stopped && char_code != CH_BACKTICK) begin
            if (is_stop) begin
                ctl_next.digits_stopped = 1'b1;
            end else begin
                acc_next = acc_sum;
            end
        end
        if (ctl.position != POS_LATER) begin
            ctl_next.position = ctl.position + 2'd1;
        end
    end

endmodule
